FILE: src/mset_pkg.sv
// ---------------------------------------------------------------------------
// mset_pkg - shared types and codes for the event slot timer table
// Command and kind codes, operand width, slot memory word.
// ---------------------------------------------------------------------------
package mset_pkg;

    localparam int OP_W   = 16;
    localparam int CMD_W  = 4;
    localparam int KIND_W = 3;

    localparam logic [CMD_W-1:0] CMD_TICK       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ARM        = 4'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REDUCE     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SET_FIRST  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SET_REJECT = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLR_REJECT = 4'd7;

    localparam logic [KIND_W-1:0] KIND_ONCE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PERIODIC  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COUNTDOWN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOCK      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHAIN     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RANGE     = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic signed [OP_W-1:0] first;
        logic signed [OP_W-1:0] second;
    } slot_word_t;

endpackage

FILE: src/multi_slot_event_timer_table.sv
// ---------------------------------------------------------------------------
// multi_slot_event_timer_table - tick driven event slot table
// Slot operands live in a one-port-read synchronous memory; firings of a
// tick walk are buffered in a second memory and replayed after the walk.
// ---------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis channel, one per transfer. Each command
//   yields one or more result transfers on m_axis: for a tick, one transfer
//   per fired slot (tuser = 1) in ascending slot order, then a status
//   transfer (tuser = 0, tlast = 1). Other commands give the status only.
//   All results of a command carry the addressed slot's fields, the armed
//   count and the tick counter as they stand after the command.
//   A tick walks all SLOTS entries, reading each armed slot from memory and
//   running the iterative remainder unit for each armed periodic slot with a
//   positive period; the walk then closes and the buffered results are replayed.
//   One command is processed at a time; s_axis_tready is high only between
//   commands. The output register lets the next command enter while the
//   last status still waits to be taken.
//   Reset clears armed, valid and reject bits and the tick counter; slot
//   memory contents need no clearing, an entry without its valid bit reads
//   as zero. A stalled receiver holds the output register and stops the
//   replay of buffered firings.
// ---------------------------------------------------------------------------
module multi_slot_event_timer_table
#(
    parameter int SLOTS     = 16,
    parameter int TICK_WRAP = 60000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] command, [6:4] kind, [10:7] slot, [26:11] first_operand,
    // [42:27] second_operand, [43] reject_flag, [47:44] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] fired_id, [31:16] entry_first, [47:32] entry_second,
    // [48] entry_rejected, [53:49] active_count, [69:54] tick_now, [71:70] zero
    output logic [71:0] m_axis_tdata,
    // [0] fired
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int W  = mset_pkg::OP_W;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // state codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_WALK_RD = 4'd1;
    localparam logic [3:0] ST_WALK_EV = 4'd2;
    localparam logic [3:0] ST_WALK_DV = 4'd3;
    localparam logic [3:0] ST_UPD_RD  = 4'd4;
    localparam logic [3:0] ST_UPD     = 4'd5;
    localparam logic [3:0] ST_FETCH_RD= 4'd6;
    localparam logic [3:0] ST_FETCH   = 4'd7;
    localparam logic [3:0] ST_EMIT_RD = 4'd8;
    localparam logic [3:0] ST_EMIT_LD = 4'd9;

    logic [3:0] state_reg, state_next;

    // latched command
    logic [mset_pkg::CMD_W-1:0]  cmd_reg;
    logic [mset_pkg::KIND_W-1:0] kind_reg;
    logic [3:0]                  slot_reg;
    logic signed [W-1:0]         opa_reg, opb_reg;
    logic                        rf_reg;

    // per-slot flag bits
    logic [SLOTS-1:0] armed_reg, armed_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] rej_reg, rej_next;
    logic [W-1:0]     tick_reg, tick_next;

    logic [CW-1:0] idx_reg, idx_next;     // walk / replay index
    logic [CW-1:0] fcnt_reg, fcnt_next;   // buffered firings

    // slot memory
    mset_pkg::slot_word_t slot_mem [SLOTS];
    mset_pkg::slot_word_t slot_rdata;
    mset_pkg::slot_word_t slot_wdata;
    mset_pkg::slot_word_t word;
    logic [SW-1:0]        slot_raddr, slot_waddr;
    logic                 slot_we;

    // fire buffer memory
    logic [W-1:0]  fire_mem [SLOTS];
    logic [W-1:0]  fire_rdata;
    logic [W-1:0]  fire_wdata;
    logic          fire_we;

    // entry fields of the addressed slot
    logic signed [W-1:0] ent_first_reg, ent_second_reg;
    logic                ent_rej_reg;
    logic                ent_load;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [71:0] out_data_reg;
    logic        out_fired_reg, out_last_reg;
    logic        out_load, out_is_fire;

    // remainder unit
    logic         rem_start, rem_done;
    logic [W-1:0] rem_val;

    logic          ok;
    logic [SW-1:0] s_idx, w_idx;
    logic          in_xfer;
    logic          out_free;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign ok       = 32'(slot_reg) < SLOTS;
    assign s_idx    = SW'(slot_reg);
    assign w_idx    = idx_reg[SW-1:0];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign word     = valid_reg[w_idx] ? slot_rdata : '0;

    mset_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (tick_reg),
        .divisor   (word.first),
        .done      (rem_done),
        .remainder (rem_val)
    );

    always_comb
    begin
        mset_pkg::slot_word_t uw;
        logic signed [W-1:0]  f;
        state_next  = state_reg;
        armed_next  = armed_reg;
        valid_next  = valid_reg;
        rej_next    = rej_reg;
        tick_next   = tick_reg;
        idx_next    = idx_reg;
        fcnt_next   = fcnt_reg;
        slot_raddr  = w_idx;
        slot_we     = 1'b0;
        slot_waddr  = w_idx;
        slot_wdata  = word;
        fire_we     = 1'b0;
        fire_wdata  = W'(idx_reg);
        rem_start   = 1'b0;
        ent_load    = 1'b0;
        out_load    = 1'b0;
        out_is_fire = 1'b0;
        uw          = valid_reg[s_idx] ? slot_rdata : '0;
        f           = word.first;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next  = '0;
                fcnt_next = '0;
                if (in_xfer)
                begin
                    case (s_axis_tdata[3:0]) inside
                        mset_pkg::CMD_TICK:       state_next = ST_WALK_RD;
                        mset_pkg::CMD_REMOVE_ALL:
                        begin
                            armed_next = '0;
                            valid_next = '0;
                            state_next = ST_FETCH_RD;
                        end
                        mset_pkg::CMD_CLR_REJECT:
                        begin
                            rej_next   = '0;
                            state_next = ST_FETCH_RD;
                        end
                        mset_pkg::CMD_ARM, mset_pkg::CMD_REMOVE, mset_pkg::CMD_REDUCE,
                        mset_pkg::CMD_SET_FIRST, mset_pkg::CMD_SET_REJECT:
                            // a slot beyond the table changes nothing
                            state_next = (32'(s_axis_tdata[10:7]) < SLOTS)
                                         ? ST_UPD_RD : ST_FETCH_RD;
                        default:                  state_next = ST_FETCH_RD;
                    endcase
                end
            end

            ST_WALK_RD:
            begin
                if (idx_reg == CW'(SLOTS))
                begin
                    tick_next  = (tick_reg == W'(TICK_WRAP - 1)) ? '0 : tick_reg + W'(1);
                    state_next = ST_FETCH_RD;
                end
                else if (!armed_reg[w_idx])
                    idx_next = idx_reg + CW'(1);
                else
                    state_next = ST_WALK_EV;
            end

            ST_WALK_EV:
            begin
                state_next = ST_WALK_RD;
                idx_next   = idx_reg + CW'(1);
                case (word.kind)
                    mset_pkg::KIND_PERIODIC:
                    begin
                        if (f > 0)
                        begin
                            rem_start  = 1'b1;
                            idx_next   = idx_reg;
                            state_next = ST_WALK_DV;
                        end
                    end
                    mset_pkg::KIND_COUNTDOWN:
                    begin
                        if (f >= 1)
                        begin
                            slot_we          = 1'b1;
                            slot_wdata.first = f - W'(1);
                        end
                        else
                        begin
                            fire_we           = 1'b1;
                            armed_next[w_idx] = 1'b0;
                        end
                    end
                    mset_pkg::KIND_LOCK:
                    begin
                        if (f <= 0)
                        begin
                            fire_we           = 1'b1;
                            armed_next[w_idx] = 1'b0;
                        end
                    end
                    mset_pkg::KIND_CHAIN:
                    begin
                        fire_we = 1'b1;
                        if (f >= 1)
                        begin
                            slot_we          = 1'b1;
                            slot_wdata.first = f - W'(1);
                        end
                        else
                        begin
                            fire_wdata        = word.second;
                            armed_next[w_idx] = 1'b0;
                        end
                    end
                    mset_pkg::KIND_RANGE:
                    begin
                        fire_we = 1'b1;
                        if (f < word.second)
                        begin
                            slot_we          = 1'b1;
                            slot_wdata.first = f + W'(1);
                        end
                        else if (f == word.second)
                            armed_next[w_idx] = 1'b0;
                    end
                    default:
                    begin
                        fire_we           = 1'b1;
                        armed_next[w_idx] = 1'b0;
                    end
                endcase
                if (fire_we)
                    fcnt_next = fcnt_reg + CW'(1);
            end

            ST_WALK_DV:
            begin
                if (rem_done)
                begin
                    if (rem_val == '0)
                    begin
                        fire_we   = 1'b1;
                        fcnt_next = fcnt_reg + CW'(1);
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_WALK_RD;
                end
            end

            ST_UPD_RD:
            begin
                slot_raddr = s_idx;
                state_next = ST_UPD;
            end

            ST_UPD:
            begin
                slot_waddr = s_idx;
                slot_wdata = uw;
                state_next = ST_FETCH_RD;
                case (cmd_reg)
                    mset_pkg::CMD_ARM:
                    begin
                        if (kind_reg <= mset_pkg::KIND_RANGE
                            && !((kind_reg == mset_pkg::KIND_ONCE
                                  || kind_reg == mset_pkg::KIND_COUNTDOWN) && rej_reg[s_idx])
                            && !(kind_reg == mset_pkg::KIND_PERIODIC && opa_reg <= 0))
                        begin
                            slot_we           = 1'b1;
                            slot_wdata.kind   = kind_reg;
                            slot_wdata.first  = (kind_reg != mset_pkg::KIND_ONCE) ? opa_reg : '0;
                            slot_wdata.second = (kind_reg == mset_pkg::KIND_CHAIN
                                                 || kind_reg == mset_pkg::KIND_RANGE)
                                                ? opb_reg : '0;
                            valid_next[s_idx] = 1'b1;
                            armed_next[s_idx] = 1'b1;
                        end
                    end
                    mset_pkg::CMD_REMOVE:
                    begin
                        valid_next[s_idx] = 1'b0;
                        armed_next[s_idx] = 1'b0;
                    end
                    mset_pkg::CMD_REDUCE:
                    begin
                        slot_we           = 1'b1;
                        valid_next[s_idx] = 1'b1;
                        if (uw.first != {1'b1, {(W-1){1'b0}}})
                            slot_wdata.first = uw.first - W'(1);
                    end
                    mset_pkg::CMD_SET_FIRST:
                    begin
                        slot_we           = 1'b1;
                        valid_next[s_idx] = 1'b1;
                        slot_wdata.first  = opa_reg;
                    end
                    mset_pkg::CMD_SET_REJECT: rej_next[s_idx] = rf_reg;
                    default: ;
                endcase
            end

            ST_FETCH_RD:
            begin
                slot_raddr = s_idx;
                state_next = ST_FETCH;
            end

            ST_FETCH:
            begin
                ent_load   = 1'b1;
                idx_next   = '0;
                state_next = ST_EMIT_RD;
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (idx_reg == fcnt_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        out_is_fire = 1'b1;
                        idx_next    = idx_reg + CW'(1);
                        state_next  = ST_EMIT_RD;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            armed_reg     <= '0;
            valid_reg     <= '0;
            rej_reg       <= '0;
            tick_reg      <= '0;
            idx_reg       <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            valid_reg     <= valid_next;
            rej_reg       <= rej_next;
            tick_reg      <= tick_next;
            idx_reg       <= idx_next;
            fcnt_reg      <= fcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // slot memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rdata <= slot_mem[slot_raddr];
    end

    // fire buffer
    always_ff @(posedge clk)
    begin
        if (fire_we)
            fire_mem[fcnt_reg[SW-1:0]] <= fire_wdata;
        fire_rdata <= fire_mem[idx_reg[SW-1:0]];
    end

    // command latch, entry fields and output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg  <= s_axis_tdata[3:0];
            kind_reg <= s_axis_tdata[6:4];
            slot_reg <= s_axis_tdata[10:7];
            opa_reg  <= s_axis_tdata[26:11];
            opb_reg  <= s_axis_tdata[42:27];
            rf_reg   <= s_axis_tdata[43];
        end
        if (ent_load)
        begin
            ent_first_reg  <= (ok && valid_reg[s_idx]) ? slot_rdata.first : '0;
            ent_second_reg <= (ok && valid_reg[s_idx]) ? slot_rdata.second : '0;
            ent_rej_reg    <= ok ? rej_reg[s_idx] : 1'b0;
        end
        if (out_load)
        begin
            out_fired_reg <= out_is_fire;
            out_last_reg  <= !out_is_fire;
            out_data_reg  <= {2'b00, tick_reg, 5'($countones(armed_reg)), ent_rej_reg,
                              ent_second_reg, ent_first_reg,
                              out_is_fire ? fire_rdata : W'(0)};
        end
    end

    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_fired_reg;
    assign m_axis_tlast    = out_last_reg;

endmodule

FILE: src/mset_rem.sv
// ---------------------------------------------------------------------------
// mset_rem - iterative unsigned remainder
// Restoring shift-subtract, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mset_rem
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mset_pkg::OP_W-1:0]   dividend,
    input  logic [mset_pkg::OP_W-1:0]   divisor,
    output logic                        done,
    output logic [mset_pkg::OP_W-1:0]   remainder
);

    localparam int W  = mset_pkg::OP_W;
    localparam int NW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dq_reg, dq_next;
    logic [W-1:0]  div_reg, div_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dq_reg[W-1]};
        if (start)
        begin
            rem_next  = '0;
            dq_next   = dividend;
            div_next  = divisor;
            cnt_next  = NW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                trial = trial - {1'b0, div_reg};
            rem_next = trial[W-1:0];
            dq_next  = {dq_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: sim/tb_multi_slot_event_timer_table.sv
// ---------------------------------------------------------------------------
// tb_multi_slot_event_timer_table - stream testbench for the event slot table
// Drives commands on s_axis, predicts every firing and status transfer with
// an in-bench slot table model, and checks m_axis transfers field by field.
// ---------------------------------------------------------------------------
module tb_multi_slot_event_timer_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT     = 16;
    localparam int WRAP      = 60000;
    localparam int STALL_MAX = 20000;

    // predicted result of one m_axis transfer
    typedef struct packed {
        logic                             fired;
        logic signed [mset_pkg::OP_W-1:0] fired_id;
        logic                             last;
        logic signed [mset_pkg::OP_W-1:0] e_first;
        logic signed [mset_pkg::OP_W-1:0] e_second;
        logic                             e_rej;
        logic [4:0]                       count;
        logic [15:0]                      tick;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [3:0] cmd [6:4] kind [10:7] slot [26:11] a
                                 // [42:27] b [43] reject_flag
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // [15:0] id [31:16] first [47:32] second
                                 // [48] rej [53:49] count [69:54] tick
    logic [0:0]  m_axis_tuser;   // [0] fired
    logic        m_axis_tlast;

    multi_slot_event_timer_table u_top (.*);

    // model state of the slot table
    logic                             mdl_armed [NSLOT];
    logic [mset_pkg::KIND_W-1:0]      mdl_kind  [NSLOT];
    logic signed [mset_pkg::OP_W-1:0] mdl_first [NSLOT];
    logic signed [mset_pkg::OP_W-1:0] mdl_second[NSLOT];
    logic                             mdl_rej   [NSLOT];
    int                               mdl_tick;

    status_t expected_q[$];
    int      errors;
    int      src_idle_pct;
    int      snk_stall_pct;
    bit      snk_hold;
    int      quiet_cycles;

    always
    begin
        clk = 1'b0; #1;
        clk = 1'b1; #1;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic void clear_entry(input int s);
        mdl_armed[s]  = 1'b0;
        mdl_kind[s]   = mset_pkg::KIND_ONCE;
        mdl_first[s]  = '0;
        mdl_second[s] = '0;
    endfunction

    // apply one command to the model and queue its transfers
    function automatic void predict_command(input logic [3:0] cmd, input logic [2:0] kind,
                                            input logic [3:0] s,
                                            input logic signed [15:0] a,
                                            input logic signed [15:0] b, input logic rf);
        status_t       res;
        logic [15:0]   ids[$];
        int            cnt;
        ids = {};
        cnt = 0;
        if (cmd == mset_pkg::CMD_TICK) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!mdl_armed[i])
                    continue;
                case (mdl_kind[i])
                    mset_pkg::KIND_PERIODIC:
                        if (mdl_first[i] > 0 && (mdl_tick % int'(mdl_first[i])) == 0)
                            ids.push_back(16'(i));
                    mset_pkg::KIND_COUNTDOWN:
                        if (mdl_first[i] >= 1) mdl_first[i] -= 1;
                        else begin ids.push_back(16'(i)); mdl_armed[i] = 1'b0; end
                    mset_pkg::KIND_LOCK:
                        if (mdl_first[i] <= 0) begin
                            ids.push_back(16'(i));
                            mdl_armed[i] = 1'b0;
                        end
                    mset_pkg::KIND_CHAIN:
                        if (mdl_first[i] >= 1) begin
                            ids.push_back(16'(i));
                            mdl_first[i] -= 1;
                        end
                        else begin ids.push_back(mdl_second[i]); mdl_armed[i] = 1'b0; end
                    mset_pkg::KIND_RANGE:
                    begin
                        ids.push_back(16'(i));
                        if (mdl_first[i] < mdl_second[i]) mdl_first[i] += 1;
                        else if (mdl_first[i] == mdl_second[i]) mdl_armed[i] = 1'b0;
                    end
                    default:
                    begin
                        ids.push_back(16'(i));
                        mdl_armed[i] = 1'b0;
                    end
                endcase
            end
            mdl_tick = (mdl_tick + 1 >= WRAP) ? 0 : mdl_tick + 1;
        end else if (cmd == mset_pkg::CMD_REMOVE_ALL) begin
            for (int i = 0; i < NSLOT; i++) clear_entry(i);
        end else if (cmd == mset_pkg::CMD_CLR_REJECT) begin
            for (int i = 0; i < NSLOT; i++) mdl_rej[i] = 1'b0;
        end else begin
            case (cmd)
                mset_pkg::CMD_ARM:
                    // unknown kinds, rejected once/countdown and bad periods do nothing
                    if (!(kind > mset_pkg::KIND_RANGE
                          || ((kind == mset_pkg::KIND_ONCE || kind == mset_pkg::KIND_COUNTDOWN)
                              && mdl_rej[s])
                          || (kind == mset_pkg::KIND_PERIODIC && a <= 0))) begin
                        clear_entry(s);
                        mdl_kind[s]  = kind;
                        mdl_armed[s] = 1'b1;
                        if (kind != mset_pkg::KIND_ONCE) mdl_first[s] = a;
                        if (kind == mset_pkg::KIND_CHAIN || kind == mset_pkg::KIND_RANGE)
                            mdl_second[s] = b;
                    end
                mset_pkg::CMD_REMOVE:     clear_entry(s);
                mset_pkg::CMD_REDUCE:     if (mdl_first[s] != -16'sd32768) mdl_first[s] -= 1;
                mset_pkg::CMD_SET_FIRST:  mdl_first[s] = a;
                mset_pkg::CMD_SET_REJECT: mdl_rej[s] = rf;
                default: ;
            endcase
        end
        for (int i = 0; i < NSLOT; i++) cnt += mdl_armed[i];
        res.e_first  = mdl_first[s];
        res.e_second = mdl_second[s];
        res.e_rej    = mdl_rej[s];
        res.count    = cnt[4:0];
        res.tick     = mdl_tick[15:0];
        foreach (ids[k]) begin
            res.fired = 1'b1; res.fired_id = ids[k]; res.last = 1'b0;
            expected_q.push_back(res);
        end
        res.fired = 1'b0; res.fired_id = '0; res.last = 1'b1;
        expected_q.push_back(res);
    endfunction

    // one command transfer, with random idle gaps before it
    task automatic send_command(input logic [3:0] cmd, input logic [2:0] kind,
                                input logic [3:0] s, input logic signed [15:0] a,
                                input logic signed [15:0] b, input logic rf);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, rf, b, a, s, kind, cmd};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_command(cmd, kind, s, a, b, rf);
    endtask

    // receiver ready with random stalls, plus an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !snk_hold && ($urandom_range(99) >= snk_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        status_t got;
        status_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tlast, m_axis_tdata[31:16],
                   m_axis_tdata[47:32], m_axis_tdata[48], m_axis_tdata[53:49],
                   m_axis_tdata[69:54]};
            if (expected_q.size() == 0)
                report_mismatch("transfer with nothing expected");
            else begin
                exp_r = expected_q.pop_front();
                if (got.fired != exp_r.fired)       report_mismatch("fired");
                if (got.fired_id != exp_r.fired_id) report_mismatch($sformatf(
                    "fired_id %0d exp %0d", got.fired_id, exp_r.fired_id));
                if (got.last != exp_r.last)         report_mismatch("last");
                if (got.e_first != exp_r.e_first)   report_mismatch("entry_first");
                if (got.e_second != exp_r.e_second) report_mismatch("entry_second");
                if (got.e_rej != exp_r.e_rej)       report_mismatch("entry_rejected");
                if (got.count != exp_r.count)       report_mismatch("active_count");
                if (got.tick != exp_r.tick)         report_mismatch("tick_now");
            end
        end
    end

    // watchdog: cycles without any transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX + 5000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_operand();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'($urandom_range(0, 8));
            3:       return -$signed({1'b0, 4'($urandom_range(0, 8))});
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_command(mset_pkg::CMD_SET_REJECT, 0, 1, 0, 0, 1);
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_ONCE, 1, 5, 5, 0);      // rejected once
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_COUNTDOWN, 1, 2, 0, 0); // rejected
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_LOCK, 1, 1, 0, 0);      // ignores reject
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_ONCE, 0, 16'sh7fff, 16'sh8000, 0);
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_PERIODIC, 2, 0, 0, 0);  // bad period
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_PERIODIC, 2, 3, 0, 0);
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_COUNTDOWN, 3, 1, 0, 0);
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_CHAIN, 4, 1, 16'sh8000, 0);
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_RANGE, 5, 16'sh7ffe, 16'sh7fff, 0);
        send_command(mset_pkg::CMD_ARM, mset_pkg::KIND_RANGE, 6, 3, -2, 0);    // stays armed
        send_command(mset_pkg::CMD_ARM, 3'd6, 7, 1, 1, 0);                     // unknown kind
        send_command(mset_pkg::CMD_ARM, 3'd7, 7, 1, 1, 0);
        send_command(mset_pkg::CMD_REDUCE, 0, 1, 0, 0, 0);
        send_command(mset_pkg::CMD_SET_FIRST, 0, 8, 16'sh8000, 0, 0);
        send_command(mset_pkg::CMD_REDUCE, 0, 8, 0, 0, 0);                     // saturates
        for (int i = 0; i < 4; i++) send_command(mset_pkg::CMD_TICK, 0, 5, 0, 0, 0);
        send_command(mset_pkg::CMD_SET_FIRST, 0, 2, -1, 0, 0);   // periodic never fires
        send_command(mset_pkg::CMD_TICK, 0, 2, 0, 0, 0);
        send_command(4'd9, 7, 15, 16'sh7fff, 16'sh7fff, 1);      // unknown acts as query
        send_command(4'd15, 0, 0, 0, 0, 0);
        send_command(mset_pkg::CMD_CLR_REJECT, 0, 1, 0, 0, 0);
        send_command(mset_pkg::CMD_REMOVE, 0, 6, 0, 0, 0);
        send_command(mset_pkg::CMD_REMOVE_ALL, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(input int n);
        logic [3:0] cmd;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2: cmd = mset_pkg::CMD_TICK;
                3, 4, 5: cmd = mset_pkg::CMD_ARM;
                6:       cmd = 4'($urandom_range(2, 7));
                7:       cmd = $urandom_range(2) ? mset_pkg::CMD_SET_FIRST
                                                 : mset_pkg::CMD_REDUCE;
                8:       cmd = $urandom_range(3) ? mset_pkg::CMD_SET_REJECT
                                                 : mset_pkg::CMD_REMOVE_ALL;
                default: cmd = 4'($urandom);
            endcase
            send_command(cmd, $urandom_range(7) < 7 ? 3'($urandom_range(5)) : 3'($urandom),
                         4'($urandom), rand_operand(), rand_operand(), 1'($urandom));
        end
    endtask

    // receiver holds off long while commands keep arriving
    task automatic test_backpressure();
        fork
            begin
                snk_hold = 1'b1;
                repeat (400) @(posedge clk);
                snk_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_command(i % 2 ? mset_pkg::CMD_TICK : mset_pkg::CMD_ARM,
                             mset_pkg::KIND_RANGE, 4'(i), 0, 4, 0);
        join
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0 && waited < STALL_MAX) begin
            @(posedge clk);
            waited++;
        end
        repeat (400) @(posedge clk);
    endtask

    initial
    begin
        mdl_tick      = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        snk_hold      = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            clear_entry(i);
            mdl_rej[i] = 1'b0;
        end
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(100);
        src_idle_pct = 46;
        test_random(100);
        src_idle_pct = 0; snk_stall_pct = 46;
        test_random(100);
        src_idle_pct = 33; snk_stall_pct = 33;
        test_random(100);
        src_idle_pct = 0; snk_stall_pct = 0;
        test_backpressure();
        drain();

        if (errors == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
